>>> hdl/hmr_pkg.sv
package hmr_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int CNT_W     = 24;
  localparam int SUM_W     = 40;
  localparam int USED_W    = 11;
  localparam int ACC_W     = 64;
  // Dividend width: a count scaled by 2^(2*FRAC_BITS)
  localparam int NUM_W     = CNT_W + 2 * FRAC_BITS;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

  // Result range, signed Q24.16
  localparam logic [SUM_W-1:0] OUT_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] OUT_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Accumulator limits
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  // One classified item as it travels from front to back
  typedef struct packed {
    logic             usable;
    logic             last;
    logic             sneg;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] smag;
  } hmr_item_t;

  // Queue write control from the front
  typedef struct packed {
    logic push;
  } hmr_qin_t;

endpackage

>>> hdl/hmr_div.sv
module hmr_div
  import hmr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [ACC_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W);

  logic [ACC_W-1:0] rem;
  logic [ACC_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic [ACC_W:0]   trial;
  logic             qbit;
  logic [ACC_W-1:0] rem_next;

  // Restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    qbit  = (trial >= {1'b0, dsr});
    if (qbit) begin
      rem_next = ACC_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[ACC_W-1:0];
    end
  end

  // Dividend bits leave the top of quo as quotient bits enter the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dsr  <= den;
        quo  <= num;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/hmr_fifo.sv
module hmr_fifo
  import hmr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  hmr_qin_t  qin_ctl,
  input  hmr_item_t wr_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output hmr_item_t rd_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  hmr_item_t     mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] fill;

  assign full    = (fill == NW'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_item = mem[rptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (qin_ctl.push) begin
      mem[wptr] <= wr_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (qin_ctl.push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (qin_ctl.push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !qin_ctl.push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> hdl/hmr_front.sv
module hmr_front
  import hmr_pkg::*;
(
  input  logic                    start,
  output logic                    busy,
  input  logic        [CNT_W-1:0] hit_count,
  input  logic signed [SUM_W-1:0] target_sum,
  input  logic                    last,
  input  logic                    q_full,
  output hmr_qin_t                qin_ctl,
  output hmr_item_t               item
);

  logic take;

  assign busy = q_full;
  assign take = start && !q_full;

  // Classify: magnitude and sign of the target sum, skip empty entries
  always_comb begin
    item.sneg   = target_sum[SUM_W-1];
    item.smag   = item.sneg ? SUM_W'(~target_sum + 1'b1) : target_sum;
    item.count  = hit_count;
    item.last   = last;
    item.usable = (hit_count != '0) && (target_sum != '0);
  end

  // Skipped entries that do not close an evaluation leave no trace
  always_comb begin
    qin_ctl.push = take && (item.usable || last);
  end

endmodule

>>> hdl/hmr_back.sv
module hmr_back
  import hmr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    empty,
  input  hmr_item_t               head,
  output logic                    pop,
  output logic                    valid,
  output logic signed [SUM_W-1:0] mean_value,
  output logic        [1:0]       status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RDIV  = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;
  localparam logic [1:0] S_FDIV  = 2'd3;

  localparam logic [NUM_W-1:0] LIM = NUM_W'(1) << (SUM_W - 1);

  logic [1:0]        state;
  logic [ACC_W-1:0]  acc;
  logic [USED_W-1:0] used;
  logic              cur_last;
  logic              cur_neg;

  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [ACC_W-1:0]  div_den;
  logic              div_busy;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;

  logic [ACC_W-1:0]  recip;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_next;
  logic [ACC_W-1:0]  acc_mag;
  logic [NUM_W-1:0]  neg_quo;
  logic [SUM_W-1:0]  res_clamped;

  hmr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Divider launch: a reciprocal from the queue head, or the final quotient
  always_comb begin
    pop       = (state == S_IDLE) && !empty;
    acc_mag   = acc[ACC_W-1] ? ACC_W'(~acc + 1'b1) : acc;
    div_start = 1'b0;
    div_num   = {head.count, {(2*FRAC_BITS){1'b0}}};
    div_den   = {{(ACC_W-SUM_W){1'b0}}, head.smag};
    if (pop && head.usable) begin
      div_start = 1'b1;
    end else if (state == S_FINAL && used != '0 && acc != '0) begin
      div_start = 1'b1;
      div_num   = {{(CNT_W-USED_W){1'b0}}, used, {(2*FRAC_BITS){1'b0}}};
      div_den   = acc_mag;
    end
  end

  // Signed reciprocal and saturating accumulate
  always_comb begin
    recip   = {{(ACC_W-NUM_W){1'b0}}, div_quo};
    if (cur_neg) begin
      recip = ACC_W'(~recip + 1'b1);
    end
    acc_sum = {acc[ACC_W-1], acc} + {recip[ACC_W-1], recip};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_next = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = acc_sum[ACC_W-1:0];
    end
  end

  // Sign and clamp of the final quotient
  always_comb begin
    neg_quo = NUM_W'(~div_quo + 1'b1);
    if (cur_neg) begin
      res_clamped = (div_quo > LIM) ? OUT_MIN : neg_quo[SUM_W-1:0];
    end else begin
      res_clamped = (div_quo >= LIM) ? OUT_MAX : div_quo[SUM_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc   <= '0;
      used  <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur_last <= head.last;
            cur_neg  <= head.sneg;
            state    <= head.usable ? S_RDIV : S_FINAL;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            acc   <= acc_next;
            if (used != USED_MAX) begin
              used <= used + 1'b1;
            end
            state <= cur_last ? S_FINAL : S_IDLE;
          end
        end
        S_FINAL: begin
          if (used == '0) begin
            valid      <= 1'b1;
            mean_value <= '0;
            status     <= ST_EMPTY;
            state      <= S_IDLE;
          end else if (acc == '0) begin
            valid      <= 1'b1;
            mean_value <= OUT_MAX;
            status     <= ST_ZERO;
            used       <= '0;
            state      <= S_IDLE;
          end else begin
            cur_neg <= acc[ACC_W-1];
            state   <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            valid      <= 1'b1;
            mean_value <= res_clamped;
            status     <= ST_OK;
            acc        <= '0;
            used       <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while running");

  a_res_src: assert property (@(posedge clk) disable iff (rst)
    valid |-> ($past(state) == S_FINAL || $past(state) == S_FDIV))
    else $error("result outside final phase");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    valid |-> (acc == '0 && used == '0 && state == S_IDLE))
    else $error("state not cleared after result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && status == ST_EMPTY) |-> (mean_value == '0))
    else $error("empty status with nonzero mean");
`endif

endmodule

>>> hdl/harmonic_mean_of_ram_means.sv
// Channel  Handshake          Ports
// -------  -----------------  ---------------------------------
// input    start & !busy      hit_count, target_sum, last
// result   valid (1 cycle)    mean_value, status
//
// A skipped entry (zero count or zero target sum) that is not last is dropped
// at once. A usable entry holds the back end for a 56-step radix-2 division,
// launch and accumulate. With the back end idle, valid follows the last item
// after the final check (no usable entry or zero sum), the final division
// (last item skipped) or its own and the final division (last item usable);
// entries queued ahead add their work. busy is high while the queue is full.
// Reset (rst, synchronous) clears accumulator, count, queue; no result stall.
module harmonic_mean_of_ram_means
  import hmr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic        [CNT_W-1:0] hit_count,
  input  logic signed [SUM_W-1:0] target_sum,
  input  logic                    last,
  output logic                    valid,
  output logic signed [SUM_W-1:0] mean_value,
  output logic        [1:0]       status
);

  hmr_qin_t  qin_ctl;
  hmr_item_t wr_item;
  hmr_item_t head;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  hmr_front u_front (
    .start      (start),
    .busy       (busy),
    .hit_count  (hit_count),
    .target_sum (target_sum),
    .last       (last),
    .q_full     (q_full),
    .qin_ctl    (qin_ctl),
    .item       (wr_item)
  );

  hmr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .qin_ctl (qin_ctl),
    .wr_item (wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (head)
  );

  hmr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (q_empty),
    .head       (head),
    .pop        (q_pop),
    .valid      (valid),
    .mean_value (mean_value),
    .status     (status)
  );

endmodule
